[rtl/core/rlsad_pkg.sv]
package rlsad_pkg;

  // Default predictor capacity (largest usable order)
  localparam int unsigned MaxOrderDef = 16;

  // Register map, byte address = 4 * index
  typedef enum logic [2:0] {
    REG_ORDER   = 3'd0,
    REG_LAMBDA  = 3'd1,
    REG_VLAMBDA = 3'd2,
    REG_MU      = 3'd3,
    REG_PSTART  = 3'd4
  } reg_idx_e;

  localparam logic [4:0]  OrderRst   = 5'd4;
  localparam logic [15:0] LambdaRst  = 16'd65077;
  localparam logic [15:0] VLambdaRst = 16'd64881;
  localparam logic [7:0]  MuRst      = 8'd64;
  localparam logic [15:0] PStartRst  = 16'd1000;

  localparam logic signed [47:0] P48Max = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] P48Min = 48'sh8000_0000_0000;
  localparam logic signed [31:0] I32Max = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] I32Min = 32'sh8000_0000;

  // Divider step counts
  localparam logic [5:0] GainSteps   = 6'd31;
  localparam logic [5:0] LambdaSteps = 6'd48;

  // Datapath operations
  typedef enum logic [4:0] {
    OP_NONE   = 5'd0,
    OP_LOAD   = 5'd1,
    OP_PMAC   = 5'd2,
    OP_PFIN   = 5'd3,
    OP_HMAC   = 5'd4,
    OP_GMAC   = 5'd5,
    OP_DMAC   = 5'd6,
    OP_KDIV   = 5'd7,
    OP_KSTORE = 5'd8,
    OP_COEF   = 5'd9,
    OP_UMUL1  = 5'd10,
    OP_UMUL2  = 5'd11,
    OP_USUB   = 5'd12,
    OP_UDIV   = 5'd13,
    OP_UWR    = 5'd14,
    OP_V1     = 5'd15,
    OP_V2     = 5'd16,
    OP_V3     = 5'd17,
    OP_FIN    = 5'd18
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   first;   // first term of a sum
    logic   last;    // last term of a sum
    logic   rd_en;   // covariance read
    logic   rd_tr;   // read transposed entry
  } dp_cmd_t;

  typedef struct packed {
    logic den_pos;
    logic div_busy;
  } dp_stat_t;

  function automatic logic signed [47:0] sat48(input logic signed [57:0] v);
    logic signed [47:0] r;
    if (v[57:47] == {11{v[57]}}) r = v[47:0];
    else r = v[57] ? P48Min : P48Max;
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v[33:31] == {3{v[33]}}) r = v[31:0];
    else r = v[33] ? I32Min : I32Max;
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [29:0] v);
    logic signed [15:0] r;
    if (v[29:15] == {15{v[29]}}) r = v[15:0];
    else r = v[29] ? 16'sh8000 : 16'sh7FFF;
    return r;
  endfunction

endpackage

[rtl/core/rlsad_div.sv]
module rlsad_div import rlsad_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [47:0] divisor_i,
  input  logic [47:0] rem_i,
  input  logic [47:0] feed_i,
  input  logic [5:0]  steps_i,
  output logic        busy_o,
  output logic [47:0] quot_o
);

  logic        busy_q;
  logic [5:0]  cnt_q;
  logic [47:0] rem_q, feed_q, quot_q, div_q;
  logic [48:0] trial;

  // restoring division, one quotient bit a cycle
  assign trial = {rem_q, feed_q[47]} - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= steps_i;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 6'd1;
      if (cnt_q == 6'd1) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= rem_i;
      feed_q <= feed_i;
      div_q  <= divisor_i;
      quot_q <= '0;
    end else if (busy_q) begin
      feed_q <= {feed_q[46:0], 1'b0};
      if (!trial[48]) begin
        rem_q  <= trial[47:0];
        quot_q <= {quot_q[46:0], 1'b1};
      end else begin
        rem_q  <= {rem_q[46:0], feed_q[47]};
        quot_q <= {quot_q[46:0], 1'b0};
      end
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

[rtl/core/rlsad_cov_mem.sv]
module rlsad_cov_mem import rlsad_pkg::*; #(
  parameter int unsigned IdxW = 4,
  localparam int unsigned AddrW = 2 * IdxW,
  localparam int unsigned Depth = 1 << AddrW
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    clear_i,
  input  logic [15:0]             pstart_i,
  input  logic                    rd_en_i,
  input  logic [AddrW-1:0]        rd_addr_i,
  output logic signed [47:0]      rd_data_o,
  input  logic                    wr_en_i,
  input  logic [AddrW-1:0]        wr_addr_i,
  input  logic signed [47:0]      wr_data_i
);

  logic signed [47:0] mem_q [Depth];
  logic [Depth-1:0]   valid_q;
  logic signed [47:0] rdata_q;
  logic               rvalid_q, rdiag_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem_q[wr_addr_i] <= wr_data_i;
    if (rd_en_i) rdata_q <= mem_q[rd_addr_i];
  end

  // unwritten entries read as start value times identity
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
      rdiag_q  <= 1'b0;
    end else begin
      if (clear_i) valid_q <= '0;
      else if (wr_en_i) valid_q[wr_addr_i] <= 1'b1;
      if (rd_en_i) begin
        rvalid_q <= valid_q[rd_addr_i];
        rdiag_q  <= (rd_addr_i[AddrW-1:IdxW] == rd_addr_i[IdxW-1:0]);
      end
    end
  end

  always_comb begin
    if (rvalid_q) rd_data_o = rdata_q;
    else if (rdiag_q) rd_data_o = {8'd0, pstart_i, 24'd0};
    else rd_data_o = '0;
  end

endmodule

[rtl/core/rlsad_ctrl.sv]
module rlsad_ctrl import rlsad_pkg::*; #(
  parameter int unsigned MaxOrder = MaxOrderDef,
  localparam int unsigned CntW = $clog2(MaxOrder + 1),
  localparam int unsigned IdxW = (MaxOrder > 1) ? $clog2(MaxOrder) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  logic [4:0]      model_order_i,
  input  dp_stat_t        stat_i,
  output dp_cmd_t         cmd_o,
  output logic [IdxW-1:0] idx_i_o,
  output logic [IdxW-1:0] idx_j_o,
  output logic [CntW-1:0] order_o
);

  typedef enum logic [23:0] {
    ST_IDLE   = 24'h000001,
    ST_PRED   = 24'h000002,
    ST_PFIN   = 24'h000004,
    ST_HRD    = 24'h000008,
    ST_HMAC   = 24'h000010,
    ST_GRD    = 24'h000020,
    ST_GMAC   = 24'h000040,
    ST_DMAC   = 24'h000080,
    ST_DCHK   = 24'h000100,
    ST_KDIV   = 24'h000200,
    ST_KWAIT  = 24'h000400,
    ST_KSTORE = 24'h000800,
    ST_KCOEF  = 24'h001000,
    ST_URD    = 24'h002000,
    ST_UMUL1  = 24'h004000,
    ST_UMUL2  = 24'h008000,
    ST_USUB   = 24'h010000,
    ST_UDIV   = 24'h020000,
    ST_UWAIT  = 24'h040000,
    ST_UWR    = 24'h080000,
    ST_V1     = 24'h100000,
    ST_V2     = 24'h200000,
    ST_V3     = 24'h400000,
    ST_FIN    = 24'h800000
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] i_q, i_d, j_q, j_d, order;
  logic            out_valid_q, out_valid_d;
  logic            i_last, j_last;
  dp_cmd_t         cmd;

  // effective order, clamped to 1..MaxOrder
  always_comb begin
    if (model_order_i == 5'd0) order = CntW'(1);
    else if (32'(model_order_i) > MaxOrder) order = CntW'(MaxOrder);
    else order = CntW'(model_order_i);
  end

  assign i_last = (i_q == order - CntW'(1));
  assign j_last = (j_q == order - CntW'(1));

  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd         = '{op: OP_NONE, default: 1'b0};
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd.op  = OP_LOAD;
          i_d     = '0;
          state_d = ST_PRED;
        end
      end
      ST_PRED: begin
        cmd.op    = OP_PMAC;
        cmd.first = (i_q == '0);
        cmd.last  = i_last;
        if (i_last) begin
          i_d     = '0;
          j_d     = '0;
          state_d = ST_PFIN;
        end else i_d = i_q + CntW'(1);
      end
      ST_PFIN: begin
        cmd.op  = OP_PFIN;
        state_d = ST_HRD;
      end
      ST_HRD: begin
        cmd.rd_en = 1'b1;
        state_d   = ST_HMAC;
      end
      ST_HMAC, ST_GMAC: begin
        cmd.op    = (state_q == ST_HMAC) ? OP_HMAC : OP_GMAC;
        cmd.first = (j_q == '0);
        cmd.last  = j_last;
        state_d   = (state_q == ST_HMAC) ? ST_HRD : ST_GRD;
        if (j_last) begin
          j_d = '0;
          if (i_last) begin
            i_d     = '0;
            state_d = (state_q == ST_HMAC) ? ST_GRD : ST_DMAC;
          end else i_d = i_q + CntW'(1);
        end else j_d = j_q + CntW'(1);
      end
      ST_GRD: begin
        cmd.rd_en = 1'b1;
        cmd.rd_tr = 1'b1;
        state_d   = ST_GMAC;
      end
      ST_DMAC: begin
        cmd.op    = OP_DMAC;
        cmd.first = (i_q == '0);
        cmd.last  = i_last;
        if (i_last) begin
          i_d     = '0;
          state_d = ST_DCHK;
        end else i_d = i_q + CntW'(1);
      end
      ST_DCHK: state_d = stat_i.den_pos ? ST_KDIV : ST_V1;
      ST_KDIV: begin
        cmd.op  = OP_KDIV;
        state_d = ST_KWAIT;
      end
      ST_KWAIT: if (!stat_i.div_busy) state_d = ST_KSTORE;
      ST_KSTORE: begin
        cmd.op  = OP_KSTORE;
        state_d = ST_KCOEF;
      end
      ST_KCOEF: begin
        cmd.op = OP_COEF;
        if (i_last) begin
          i_d     = '0;
          j_d     = '0;
          state_d = ST_URD;
        end else begin
          i_d     = i_q + CntW'(1);
          state_d = ST_KDIV;
        end
      end
      ST_URD: begin
        cmd.rd_en = 1'b1;
        state_d   = ST_UMUL1;
      end
      ST_UMUL1: begin
        cmd.op  = OP_UMUL1;
        state_d = ST_UMUL2;
      end
      ST_UMUL2: begin
        cmd.op  = OP_UMUL2;
        state_d = ST_USUB;
      end
      ST_USUB: begin
        cmd.op  = OP_USUB;
        state_d = ST_UDIV;
      end
      ST_UDIV: begin
        cmd.op  = OP_UDIV;
        state_d = ST_UWAIT;
      end
      ST_UWAIT: if (!stat_i.div_busy) state_d = ST_UWR;
      ST_UWR: begin
        cmd.op  = OP_UWR;
        state_d = ST_URD;
        if (i_last) begin
          i_d = '0;
          if (j_last) state_d = ST_V1;
          else j_d = j_q + CntW'(1);
        end else i_d = i_q + CntW'(1);
      end
      ST_V1: begin
        cmd.op  = OP_V1;
        state_d = ST_V2;
      end
      ST_V2: begin
        cmd.op  = OP_V2;
        state_d = ST_V3;
      end
      ST_V3: begin
        cmd.op  = OP_V3;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.op      = OP_FIN;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;
  assign idx_i_o     = i_q[IdxW-1:0];
  assign idx_j_o     = j_q[IdxW-1:0];
  assign order_o     = order;

endmodule

[rtl/core/rlsad_dp.sv]
module rlsad_dp import rlsad_pkg::*; #(
  parameter int unsigned MaxOrder = MaxOrderDef,
  localparam int unsigned CntW = $clog2(MaxOrder + 1),
  localparam int unsigned IdxW = (MaxOrder > 1) ? $clog2(MaxOrder) : 1,
  localparam int unsigned AddrW = 2 * IdxW
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_t            cmd_i,
  input  logic [IdxW-1:0]    idx_i_i,
  input  logic [IdxW-1:0]    idx_j_i,
  input  logic [CntW-1:0]    order_i,
  output dp_stat_t           stat_o,
  input  logic signed [15:0] sample_i,
  input  logic [15:0]        lambda_i,
  input  logic [15:0]        vlambda_i,
  input  logic [7:0]         mu_i,
  input  logic [15:0]        pstart_i,
  input  logic               pstart_load_i,
  output logic signed [15:0] prediction_o,
  output logic signed [16:0] prediction_error_o,
  output logic               spike_flag_o,
  output logic [31:0]        noise_variance_o
);

  logic signed [15:0] hist_q [MaxOrder];
  logic signed [31:0] coef_q [MaxOrder];
  logic signed [47:0] h_q [MaxOrder];
  logic signed [47:0] g_q [MaxOrder];
  logic signed [31:0] k_q [MaxOrder];

  logic signed [15:0] s_q, pred_q;
  logic signed [16:0] err_q;
  logic signed [53:0] acc_q;
  logic signed [47:0] den_q, pcov_q, t_q;
  logic signed [55:0] phi_q;
  logic signed [56:0] prod_q;
  logic               ovf_q, neg_q;
  logic [32:0]        e2_q;
  logic [15:0]        mu2_q;
  logic [47:0]        vt_q, vnew_q, var_q;
  logic [4:0]         warm_q;

  // covariance memory port
  logic signed [47:0] rdata, wdata;
  logic [AddrW-1:0]   rd_addr, wr_addr;
  logic               wr_en;

  // divider port
  logic        div_start;
  logic [47:0] div_divisor, div_rem, div_feed, quot;
  logic [5:0]  div_steps;
  logic        div_busy, div_ovf, div_neg;

  logic               use_j;
  logic signed [15:0] x_sel;
  logic signed [47:0] ma;
  logic signed [63:0] mp, mp_sh;
  logic signed [53:0] acc_base, acc_n, rnd;
  logic signed [15:0] pred_n;
  logic signed [47:0] g_sel, h_sel;
  logic signed [31:0] k_sel, k_n;
  logic [47:0]        mag, qsat_mag;
  logic signed [47:0] p_new;
  logic signed [48:0] kerr;
  logic signed [55:0] phi_n;
  logic signed [56:0] plo;
  logic [15:0]        lamd;
  logic [16:0]        vw;
  logic [49:0]        vsum;
  logic [63:0]        thr;
  logic               flag;

  assign use_j = (cmd_i.op == OP_HMAC) || (cmd_i.op == OP_GMAC);
  assign x_sel = hist_q[use_j ? idx_j_i : idx_i_i];
  assign h_sel = h_q[idx_i_i];
  assign g_sel = g_q[idx_j_i];
  assign k_sel = k_q[idx_i_i];

  // shared 48x16 multiply for prediction, h, g and denominator sums
  always_comb begin
    case (cmd_i.op)
      OP_PMAC: ma = {{16{coef_q[idx_i_i][31]}}, coef_q[idx_i_i]};
      OP_DMAC: ma = h_sel;
      default: ma = rdata;
    endcase
  end

  assign mp    = ma * x_sel;
  assign mp_sh = mp >>> 15;

  always_comb begin
    if (cmd_i.first) acc_base = (cmd_i.op == OP_DMAC) ? 54'({lambda_i, 8'd0}) : '0;
    else acc_base = acc_q;
    acc_n = acc_base + ((cmd_i.op == OP_PMAC) ? mp[53:0] : mp_sh[53:0]);
  end

  assign rnd    = acc_q + 54'sd8388608;
  assign pred_n = sat16(rnd[53:24]);

  // divider operand setup: gain or lambda division
  assign lamd = (lambda_i == 16'd0) ? 16'd1 : lambda_i;
  always_comb begin
    if (cmd_i.op == OP_KDIV) begin
      div_neg     = h_sel[47];
      mag         = h_sel[47] ? 48'(-h_sel) : 48'(h_sel);
      div_ovf     = {7'd0, mag[47:7]} >= 48'(den_q);
      div_rem     = {7'd0, mag[47:7]};
      div_feed    = {mag[6:0], 41'd0};
      div_divisor = 48'(den_q);
      div_steps   = GainSteps;
    end else begin
      div_neg     = t_q[47];
      mag         = t_q[47] ? 48'(-t_q) : 48'(t_q);
      div_ovf     = mag[47:32] >= lamd;
      div_rem     = {32'd0, mag[47:32]};
      div_feed    = {mag[31:0], 16'd0};
      div_divisor = {32'd0, lamd};
      div_steps   = LambdaSteps;
    end
  end
  assign div_start = (cmd_i.op == OP_KDIV) || (cmd_i.op == OP_UDIV);

  rlsad_div u_div (
    .clk_i,
    .rst_ni,
    .start_i   (div_start),
    .divisor_i (div_divisor),
    .rem_i     (div_rem),
    .feed_i    (div_feed),
    .steps_i   (div_steps),
    .busy_o    (div_busy),
    .quot_o    (quot)
  );

  // gain: truncated toward zero, saturated to 32 bits
  always_comb begin
    if (ovf_q) k_n = neg_q ? I32Min : I32Max;
    else if (neg_q) k_n = -$signed({1'b0, quot[30:0]});
    else k_n = $signed({1'b0, quot[30:0]});
  end

  // covariance divided by lambda, saturated to 48 bits
  assign qsat_mag = quot;
  always_comb begin
    if (neg_q) begin
      if (ovf_q || (qsat_mag[47] && |qsat_mag[46:0])) p_new = P48Min;
      else p_new = -$signed(qsat_mag);
    end else begin
      if (ovf_q || qsat_mag[47]) p_new = P48Max;
      else p_new = $signed(qsat_mag);
    end
  end

  assign kerr  = k_sel * err_q;
  assign phi_n = k_sel * $signed(g_sel[47:24]);
  assign plo   = (k_sel * $signed({1'b0, g_sel[23:0]})) >>> 24;

  assign vw   = 17'h10000 - {1'b0, vlambda_i};
  assign vsum = {2'd0, vt_q} + (vw * e2_q);
  assign thr  = mu2_q * var_q;
  assign flag = (7'(warm_q) >= 7'(order_i)) && ({7'd0, e2_q, 24'd0} > thr);

  assign rd_addr = cmd_i.rd_tr ? {idx_j_i, idx_i_i} : {idx_i_i, idx_j_i};
  assign wr_addr = {idx_i_i, idx_j_i};
  assign wr_en   = (cmd_i.op == OP_UWR);
  assign wdata   = p_new;

  rlsad_cov_mem #(.IdxW(IdxW)) u_cov (
    .clk_i,
    .rst_ni,
    .clear_i   (pstart_load_i),
    .pstart_i,
    .rd_en_i   (cmd_i.rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rdata),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wdata)
  );

  // model state with defined reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < MaxOrder; n++) begin
        hist_q[n] <= '0;
        coef_q[n] <= '0;
      end
      var_q  <= '0;
      warm_q <= '0;
    end else begin
      if (cmd_i.op == OP_COEF)
        coef_q[idx_i_i] <= sat32(34'({{2{coef_q[idx_i_i][31]}}, coef_q[idx_i_i]})
                                 + 34'(kerr >>> 15));
      if (cmd_i.op == OP_FIN) begin
        for (int n = MaxOrder - 1; n > 0; n--) hist_q[n] <= hist_q[n-1];
        hist_q[0] <= s_q;
        var_q     <= vnew_q;
        if (warm_q != 5'd31) warm_q <= warm_q + 5'd1;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: s_q <= sample_i;
      OP_PMAC: acc_q <= acc_n;
      OP_PFIN: begin
        pred_q <= pred_n;
        err_q  <= 17'(s_q) - 17'(pred_n);
      end
      OP_HMAC: begin
        acc_q <= acc_n;
        if (cmd_i.last) h_q[idx_i_i] <= sat48(58'(acc_n));
      end
      OP_GMAC: begin
        acc_q <= acc_n;
        if (cmd_i.last) g_q[idx_i_i] <= sat48(58'(acc_n));
      end
      OP_DMAC: begin
        acc_q <= acc_n;
        if (cmd_i.last) den_q <= sat48(58'(acc_n));
      end
      OP_KDIV, OP_UDIV: begin
        ovf_q <= div_ovf;
        neg_q <= div_neg;
      end
      OP_KSTORE: k_q[idx_i_i] <= k_n;
      OP_UMUL1: begin
        pcov_q <= rdata;
        phi_q  <= phi_n;
      end
      OP_UMUL2: prod_q <= 57'(phi_q) + 57'($signed(plo[32:0]));
      OP_USUB: t_q <= sat48(58'(pcov_q) - 58'(prod_q));
      OP_V1: begin
        e2_q  <= 33'(34'(err_q) * 34'(err_q));
        mu2_q <= mu_i * mu_i;
      end
      OP_V2: vt_q <= 48'((64'(var_q) * 64'(vlambda_i)) >> 16);
      OP_V3: vnew_q <= (|vsum[49:48]) ? {48{1'b1}} : vsum[47:0];
      OP_FIN: begin
        prediction_o       <= pred_q;
        prediction_error_o <= err_q;
        spike_flag_o       <= flag;
        noise_variance_o   <= vnew_q[47:16];
      end
      default: ;
    endcase
  end

  assign stat_o.den_pos  = !den_q[47] && (|den_q);
  assign stat_o.div_busy = div_busy;

endmodule

[rtl/core/rls_ar_spike_detector.sv]
// Channel   Signals                                   Request carries
// -------   ---------------------------------------   ----------------------------------
// in        in_valid_i / in_ready_o                   sample_i (Q15)
// out       out_valid_o / out_ready_i                 prediction_o, prediction_error_o,
//                                                     spike_flag_o, noise_variance_o
// cfg       psel penable pwrite paddr pwdata prdata   5 registers at byte address 4*index
//
// One request at a time. The work per sample grows with the order r and is set by the
// shared radix-2 divider: 31 steps per gain, 48 per covariance entry (divide by
// lambda), and by the one covariance memory port.
// A non-positive denominator skips the update.
// Reset loads default registers; the covariance reads as start*identity until written.
// A held result does not block the next input request; the finish step waits for it.
module rls_ar_spike_detector import rlsad_pkg::*; #(
  parameter int unsigned MaxOrder = MaxOrderDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] sample_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] prediction_o,
  output logic signed [16:0] prediction_error_o,
  output logic               spike_flag_o,
  output logic [31:0]        noise_variance_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned CntW = $clog2(MaxOrder + 1);
  localparam int unsigned IdxW = (MaxOrder > 1) ? $clog2(MaxOrder) : 1;

  logic [4:0]  order_q;
  logic [15:0] lambda_q, vlambda_q, pstart_q;
  logic [7:0]  mu_q;
  logic        cfg_wr, pstart_load;
  reg_idx_e    reg_idx;

  dp_cmd_t         cmd;
  dp_stat_t        stat;
  logic [IdxW-1:0] idx_i, idx_j;
  logic [CntW-1:0] order_eff;

  // config port: zero wait states, write on access phase
  assign pready      = 1'b1;
  assign cfg_wr      = psel && penable && pwrite;
  assign reg_idx     = reg_idx_e'(paddr[4:2]);
  assign pstart_load = cfg_wr && (reg_idx == REG_PSTART);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q   <= OrderRst;
      lambda_q  <= LambdaRst;
      vlambda_q <= VLambdaRst;
      mu_q      <= MuRst;
      pstart_q  <= PStartRst;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_ORDER:   order_q   <= pwdata[4:0];
        REG_LAMBDA:  lambda_q  <= pwdata[15:0];
        REG_VLAMBDA: vlambda_q <= pwdata[15:0];
        REG_MU:      mu_q      <= pwdata[7:0];
        REG_PSTART:  pstart_q  <= pwdata[15:0];
        default: ;  // unmapped: ignored
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ORDER:   prdata = {27'd0, order_q};
      REG_LAMBDA:  prdata = {16'd0, lambda_q};
      REG_VLAMBDA: prdata = {16'd0, vlambda_q};
      REG_MU:      prdata = {24'd0, mu_q};
      REG_PSTART:  prdata = {16'd0, pstart_q};
      default:     prdata = '0;
    endcase
  end

  // sequencer: loops over order, issues datapath steps
  rlsad_ctrl #(.MaxOrder(MaxOrder)) u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .out_valid_o,
    .out_ready_i,
    .model_order_i (order_q),
    .stat_i        (stat),
    .cmd_o         (cmd),
    .idx_i_o       (idx_i),
    .idx_j_o       (idx_j),
    .order_o       (order_eff)
  );

  // predictor, RLS update, variance tracker, result register
  rlsad_dp #(.MaxOrder(MaxOrder)) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i              (cmd),
    .idx_i_i            (idx_i),
    .idx_j_i            (idx_j),
    .order_i            (order_eff),
    .stat_o             (stat),
    .sample_i,
    .lambda_i           (lambda_q),
    .vlambda_i          (vlambda_q),
    .mu_i               (mu_q),
    .pstart_i           (pstart_q),
    .pstart_load_i      (pstart_load),
    .prediction_o,
    .prediction_error_o,
    .spike_flag_o,
    .noise_variance_o
  );

endmodule

[bench/rls_ar_spike_checker.sv]
`timescale 1ns / 1ps

module rls_ar_spike_checker import rlsad_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic signed [15:0] sample_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [15:0] prediction_i,
  input  logic signed [16:0] prediction_error_i,
  input  logic               spike_flag_i,
  input  logic [31:0]        noise_variance_i,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [4:0]         paddr_i,
  input  logic [31:0]        pwdata_i,
  input  logic               pready_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam longint CovMax = 64'sh7FFF_FFFF_FFFF;
  localparam longint CovMin = -64'sh8000_0000_0000;
  localparam longint CoefMax = 64'sh7FFF_FFFF;
  localparam longint CoefMin = -64'sh8000_0000;

  typedef struct {
    logic signed [15:0] prediction;
    logic signed [16:0] prediction_error;
    logic               spike_flag;
    logic [31:0]        noise_variance;
  } detect_result_t;

  detect_result_t result_q[$];

  logic [4:0]  order_q;
  logic [15:0] lambda_q, vlambda_q, pstart_q;
  logic [7:0]  mu_q;
  longint hist_q[16];
  longint coef_q[16];
  longint cov_q[256];
  longint unsigned var_q;
  int unsigned warm_q;

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint gain_quot(longint num, longint den);
    bit neg;
    longint unsigned mag, d, q, rem;
    neg = num < 0;
    mag = neg ? longint'(-num) : longint'(num);
    d   = den;
    q   = mag / d;
    rem = mag % d;
    if (q >= 128) return neg ? CoefMin : CoefMax;
    for (int b = 0; b < 24; b++) begin
      rem = rem << 1;
      q   = q << 1;
      if (rem >= d) begin
        rem = rem - d;
        q   = q | 1;
      end
    end
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint scale_by_lambda(longint t, logic [15:0] lam);
    bit neg;
    longint unsigned mag, r, lv;
    neg = t < 0;
    mag = neg ? longint'(-t) : longint'(t);
    lv  = (lam == 0) ? 1 : lam;
    r   = (mag << 16) / lv;
    if (neg) return (r > longint'(CovMax) + 1) ? CovMin : -longint'(r);
    return (r > longint'(CovMax)) ? CovMax : longint'(r);
  endfunction

  task automatic load_cov();
    for (int i = 0; i < 256; i++) cov_q[i] = 0;
    for (int i = 0; i < 16; i++) cov_q[i * 16 + i] = longint'(pstart_q) << 24;
  endtask

  // Predict one sample, update the adaptive model, queue the expected result.
  task automatic predict_sample(input logic signed [15:0] smp);
    int r;
    longint s, acc, pred, err, den, sh, sg, gh, gl, prod, t;
    longint hv[16], gv[16], kv[16];
    longint unsigned e2, vnew, mu2, nv;
    bit flag;
    detect_result_t res;
    r = order_q;
    if (r < 1) r = 1;
    if (r > 16) r = 16;
    s = smp;
    acc = 0;
    for (int i = 0; i < r; i++) acc += coef_q[i] * hist_q[i];
    pred = clip((acc + (64'sd1 <<< 23)) >>> 24, -32768, 32767);
    err = s - pred;

    den = longint'(lambda_q) << 8;
    for (int i = 0; i < r; i++) begin
      sh = 0;
      sg = 0;
      for (int j = 0; j < r; j++) begin
        sh += (cov_q[i * 16 + j] * hist_q[j]) >>> 15;
        sg += (hist_q[j] * cov_q[j * 16 + i]) >>> 15;
      end
      hv[i] = clip(sh, CovMin, CovMax);
      gv[i] = clip(sg, CovMin, CovMax);
    end
    for (int i = 0; i < r; i++) den += (hv[i] * hist_q[i]) >>> 15;
    den = clip(den, CovMin, CovMax);
    // non-positive denominator: model left as is
    if (den > 0) begin
      for (int i = 0; i < r; i++) begin
        kv[i] = gain_quot(hv[i], den);
        coef_q[i] = clip(coef_q[i] + ((kv[i] * err) >>> 15), CoefMin, CoefMax);
      end
      for (int j = 0; j < r; j++) begin
        gh = gv[j] >>> 24;
        gl = gv[j] - (gh <<< 24);
        for (int i = 0; i < r; i++) begin
          prod = kv[i] * gh + ((kv[i] * gl) >>> 24);
          t = clip(cov_q[i * 16 + j] - prod, CovMin, CovMax);
          cov_q[i * 16 + j] = scale_by_lambda(t, lambda_q);
        end
      end
    end

    // variance products wrap at 64 bits on purpose
    e2 = longint'(err * err);
    vnew = ((var_q * longint'(vlambda_q)) >> 16) + longint'(65536 - vlambda_q) * e2;
    if (vnew > 64'hFFFF_FFFF_FFFF) vnew = 64'hFFFF_FFFF_FFFF;
    mu2 = longint'(mu_q) * longint'(mu_q);
    flag = (warm_q >= r) && ((e2 << 24) > mu2 * var_q);
    var_q = vnew;

    for (int i = 15; i > 0; i--) hist_q[i] = hist_q[i - 1];
    hist_q[0] = s;
    if (warm_q < 31) warm_q++;

    nv = vnew >> 16;
    if (nv > 64'hFFFF_FFFF) nv = 64'hFFFF_FFFF;
    res.prediction       = pred[15:0];
    res.prediction_error = err[16:0];
    res.spike_flag       = flag;
    res.noise_variance   = nv[31:0];
    result_q = {result_q, res};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    detect_result_t want;
    int errs;
    errs = 0;
    if (!rst_ni) begin
      order_q   = OrderRst;
      lambda_q  = LambdaRst;
      vlambda_q = VLambdaRst;
      mu_q      = MuRst;
      pstart_q  = PStartRst;
      for (int i = 0; i < 16; i++) begin
        hist_q[i] = 0;
        coef_q[i] = 0;
      end
      for (int i = 0; i < 256; i++) cov_q[i] = 0;
      for (int i = 0; i < 16; i++) cov_q[i * 16 + i] = longint'(PStartRst) << 24;
      var_q = 0;
      warm_q = 0;
      result_q.delete();
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[4:2])
          REG_ORDER:   order_q   = pwdata_i[4:0];
          REG_LAMBDA:  lambda_q  = pwdata_i[15:0];
          REG_VLAMBDA: vlambda_q = pwdata_i[15:0];
          REG_MU:      mu_q      = pwdata_i[7:0];
          REG_PSTART: begin
            pstart_q = pwdata_i[15:0];
            load_cov();
          end
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) predict_sample(sample_i);
      if (out_valid_i && out_ready_i) begin
        if (result_q.size() == 0) begin
          $error("result with no pending request");
          errs++;
        end else begin
          want = result_q.pop_front();
          if (prediction_i !== want.prediction) begin
            $error("prediction: expected %0d got %0d", want.prediction, prediction_i);
            errs++;
          end
          if (prediction_error_i !== want.prediction_error) begin
            $error("prediction_error: expected %0d got %0d",
                   want.prediction_error, prediction_error_i);
            errs++;
          end
          if (spike_flag_i !== want.spike_flag) begin
            $error("spike_flag: expected %0d got %0d", want.spike_flag, spike_flag_i);
            errs++;
          end
          if (noise_variance_i !== want.noise_variance) begin
            $error("noise_variance: expected %0d got %0d",
                   want.noise_variance, noise_variance_i);
            errs++;
          end
        end
      end
      fail_count_o <= fail_count_o + errs;
      pending_o <= result_q.size();
    end
  end

endmodule

[bench/tb_rls_ar_spike_detector.sv]
`timescale 1ns / 1ps

module tb_rls_ar_spike_detector import rlsad_pkg::*;;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [15:0] sample_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [15:0] prediction_o;
  logic signed [16:0] prediction_error_o;
  logic               spike_flag_o;
  logic [31:0]        noise_variance_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  int fail_count;
  int pending;
  int cycle_cnt = 0;
  logic signed [15:0] wave_q = '0;  // running value of the smooth test signal

  always #5 clk_i = ~clk_i;
  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  rls_ar_spike_detector u_dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .sample_i,
    .out_valid_o, .out_ready_i,
    .prediction_o, .prediction_error_o, .spike_flag_o, .noise_variance_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // Watches all three ports, predicts every result and compares.
  rls_ar_spike_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .sample_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .prediction_i(prediction_o), .prediction_error_i(prediction_error_o),
    .spike_flag_i(spike_flag_o), .noise_variance_i(noise_variance_o),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .pready_i(pready),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Offer one request; returns at the falling edge after it is taken, so
  // the caller either offers the next one or drops valid with one assignment.
  task automatic send_sample(input logic signed [15:0] s);
    in_valid_i <= 1'b1;
    sample_i   <= s;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic idle_gap(input int n);
    in_valid_i <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  // APB write: setup then access phase.
  task automatic reg_write(input reg_idx_e idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Block idle: all results in, then a margin for the finish step.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  // Mostly a slowly drifting signal with rare spikes, sometimes full-range noise.
  function automatic logic signed [15:0] next_sample();
    int v;
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 4) begin
      v = $signed(16'($urandom));
    end else if (pick == 4) begin
      v = $urandom_range(0, 1) ? 32767 - $urandom_range(0, 2000)
                               : -32768 + $urandom_range(0, 2000);
    end else begin
      v = wave_q + $signed($urandom_range(0, 1000)) - 500;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      wave_q = 16'(v);
    end
    return 16'(v);
  endfunction

  // Bursts of back-to-back requests separated by random gaps.
  task automatic run_random(input int n);
    int left;
    int burst;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 8);
      if (burst > left) burst = left;
      repeat (burst) send_sample(next_sample());
      left -= burst;
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 30));
    end
  endtask

  // Receiver: random stall pattern with ready-only stretches, plus one
  // long hold-off so the block holds its result and blocks new requests.
  initial begin
    int hold_cnt;
    bit held;
    held = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && cycle_cnt > 30000) begin
        held = 1;
        out_ready_i <= 1'b0;
        hold_cnt = 0;
        while (hold_cnt < 3000) begin
          @(negedge clk_i);
          hold_cnt++;
        end
      end
      case ($urandom_range(0, 3))
        0: out_ready_i <= 1'b0;
        1: out_ready_i <= ($urandom_range(0, 1) == 1);
        default: out_ready_i <= 1'b1;
      endcase
    end
  end

  initial begin
    int ord;
    int cnt;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed, default setup. Zeros keep the variance at zero, so the first
    // nonzero error after warm-up must flag; then the sample extremes.
    repeat (5) send_sample(16'sd0);
    send_sample(16'sd1000);
    send_sample(16'sh7FFF);
    send_sample(-16'sh8000);
    send_sample(16'sh7FFF);
    send_sample(-16'sh8000);
    send_sample(16'sd1);
    send_sample(-16'sd1);
    drain();

    // Zero lambda with an all-zero history: denominator not positive, skip; then nonzero samples.
    reg_write(REG_ORDER, 32'd1);
    reg_write(REG_LAMBDA, 32'd0);
    reg_write(REG_PSTART, 32'd1);
    repeat (16) send_sample(16'sd0);
    send_sample(16'sd12000);
    send_sample(-16'sd7);
    drain();

    // Extreme register values, order zero acts as one.
    reg_write(REG_ORDER, 32'd0);
    reg_write(REG_LAMBDA, 32'd65535);
    reg_write(REG_VLAMBDA, 32'd0);
    reg_write(REG_MU, 32'd255);
    reg_write(REG_PSTART, 32'd65535);
    send_sample(16'sh7FFF);
    send_sample(16'sd0);
    send_sample(-16'sh8000);
    drain();
    reg_write(REG_VLAMBDA, 32'd65535);
    reg_write(REG_MU, 32'd0);
    send_sample(16'sd300);
    send_sample(-16'sd300);
    drain();

    // Random phases; large orders are slow so they get few requests.
    for (int ph = 0; ph < 11; ph++) begin
      case (ph)
        3:  begin ord = 16; cnt = 6;  end
        6:  begin ord = 31; cnt = 3;  end
        8:  begin ord = 8;  cnt = 15; end
        default: begin ord = $urandom_range(1, 4); cnt = 65; end
      endcase
      reg_write(REG_ORDER, ord);
      reg_write(REG_LAMBDA, $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                      : $urandom_range(60000, 65535));
      reg_write(REG_VLAMBDA, $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                       : $urandom_range(62000, 65535));
      reg_write(REG_MU, $urandom_range(0, 255));
      reg_write(REG_PSTART, $urandom_range(1, 65535));
      run_random(cnt);
      drain();
    end

    if (fail_count == 0) begin
      $display("rls_ar_spike_detector test passed");
    end else begin
      $display("rls_ar_spike_detector test failed");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("rls_ar_spike_detector test failed");
    $finish;
  end

endmodule
